[sv/sdlp_pkg.sv]
// Shared types and constants for the signed decimal list parser.
`timescale 1ns / 1ps
package sdlp_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [31:0] LimitDiv10 = 32'd214748364;
  localparam logic [3:0]  LastDigitPos = 4'd7;
  localparam logic [3:0]  LastDigitNeg = 4'd8;

  typedef enum logic [2:0] {
    OP_NUL   = 3'd0,
    OP_SPACE = 3'd1,
    OP_PLUS  = 3'd2,
    OP_MINUS = 3'd3,
    OP_DIGIT = 3'd4,
    OP_BAD   = 3'd5
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [3:0] digit;
  } op_t;

endpackage

[sv/signed_decimal_list_parser.sv]
// Top level of the signed decimal list parser.
// The operation classified from a character word is held in the queue; the result
// word it causes is then held in the output register, which drives the output.
// Throughput: one character word per cycle while the queue is not full, set by the
// combinational multiply-by-ten and add in the back end; a four-entry queue
// decouples front and back.
// Reset (async, active low) empties the queue, clears token state and output valid.
`timescale 1ns / 1ps
module signed_decimal_list_parser import sdlp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         ch_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic signed [31:0] value_o,
  output logic               has_value_o,
  output logic               overflow_o,
  output logic               bad_char_o,
  output logic               end_of_string_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  logic push;
  op_t  push_op;
  logic q_full;
  logic q_empty;
  logic pop;
  op_t  pop_op;

  sdlp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_i       (ch_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  sdlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .pop_op_o  (pop_op)
  );

  sdlp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_op_i          (pop_op),
    .pop_o           (pop),
    .value_o         (value_o),
    .has_value_o     (has_value_o),
    .overflow_o      (overflow_o),
    .bad_char_o      (bad_char_o),
    .end_of_string_o (end_of_string_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule

[sv/sdlp_front.sv]
// Front end: accepts character words and classifies them into operations.
`timescale 1ns / 1ps
module sdlp_front import sdlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       push_o,
  output op_t        push_op_o
);

  logic [7:0] digit_raw;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;
  assign digit_raw  = ch_i - ChZero;

  always_comb begin
    push_op_o.digit = digit_raw[3:0];
    if (ch_i == ChNul) begin
      push_op_o.kind = OP_NUL;
    end else if (ch_i == ChSpace) begin
      push_op_o.kind = OP_SPACE;
    end else if (ch_i == ChPlus) begin
      push_op_o.kind = OP_PLUS;
    end else if (ch_i == ChMinus) begin
      push_op_o.kind = OP_MINUS;
    end else if (ch_i >= ChZero && ch_i <= ChNine) begin
      push_op_o.kind = OP_DIGIT;
    end else begin
      push_op_o.kind = OP_BAD;
    end
  end

  a_push_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("word pushed into a full queue");

endmodule

[sv/sdlp_queue.sv]
// Short queue of classified operations between front and back.
`timescale 1ns / 1ps
module sdlp_queue import sdlp_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  pop_op_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  op_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o   = (count_q == CntFull);
  assign empty_o  = (count_q == '0);
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & ~empty_o;
  assign pop_op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[sv/sdlp_back.sv]
// Back end: token state, digit accumulation and the output register.
`timescale 1ns / 1ps
module sdlp_back import sdlp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  op_t                q_op_i,
  output logic               pop_o,
  output logic signed [31:0] value_o,
  output logic               has_value_o,
  output logic               overflow_o,
  output logic               bad_char_o,
  output logic               end_of_string_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic        in_tok_q, in_tok_d;
  logic        err_q, err_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] value_q, value_d;
  logic               has_value_q, has_value_d;
  logic               overflow_q, overflow_d;
  logic               bad_char_q, bad_char_d;
  logic               eos_q, eos_d;

  logic        ready;
  logic        fire;
  logic        emit;
  logic [31:0] tok_value;
  logic [31:0] eff_mag;
  logic        eff_neg;
  logic [3:0]  last_digit;
  logic        too_big;
  logic [31:0] mag_next;

  assign ready = ~out_valid_q | ~out_stall_i;
  assign fire  = ready & ~q_empty_i;
  assign pop_o = fire;

  assign tok_value  = neg_q ? (32'd0 - mag_q) : mag_q;
  assign eff_mag    = in_tok_q ? mag_q : 32'd0;
  assign eff_neg    = in_tok_q & neg_q;
  assign last_digit = eff_neg ? LastDigitNeg : LastDigitPos;
  assign too_big    = (eff_mag > LimitDiv10) ||
                      ((eff_mag == LimitDiv10) && (q_op_i.digit > last_digit));
  assign mag_next   = {eff_mag[28:0], 3'b000} + {eff_mag[30:0], 1'b0} +
                      {28'd0, q_op_i.digit};

  always_comb begin
    mag_d       = mag_q;
    neg_d       = neg_q;
    in_tok_d    = in_tok_q;
    err_d       = err_q;
    emit        = 1'b0;
    value_d     = value_q;
    has_value_d = 1'b0;
    overflow_d  = 1'b0;
    bad_char_d  = 1'b0;
    eos_d       = 1'b0;
    if (fire) begin
      value_d = '0;
      if (q_op_i.kind == OP_NUL) begin
        emit        = 1'b1;
        eos_d       = 1'b1;
        has_value_d = in_tok_q & ~err_q;
        value_d     = (in_tok_q && !err_q) ? tok_value : 32'd0;
        mag_d       = '0;
        neg_d       = 1'b0;
        in_tok_d    = 1'b0;
        err_d       = 1'b0;
      end else if (!err_q) begin
        case (q_op_i.kind)
          OP_SPACE: begin
            emit        = in_tok_q;
            has_value_d = in_tok_q;
            value_d     = in_tok_q ? tok_value : 32'd0;
            mag_d       = '0;
            neg_d       = 1'b0;
            in_tok_d    = 1'b0;
          end
          OP_PLUS, OP_MINUS: begin
            emit        = in_tok_q;
            has_value_d = in_tok_q;
            value_d     = in_tok_q ? tok_value : 32'd0;
            mag_d       = '0;
            neg_d       = (q_op_i.kind == OP_MINUS);
            in_tok_d    = 1'b1;
          end
          OP_DIGIT: begin
            in_tok_d = 1'b1;
            neg_d    = eff_neg;
            if (too_big) begin
              emit       = 1'b1;
              overflow_d = 1'b1;
              err_d      = 1'b1;
              mag_d      = eff_mag;
            end else begin
              mag_d = mag_next;
            end
          end
          default: begin
            emit       = 1'b1;
            bad_char_d = 1'b1;
            err_d      = 1'b1;
          end
        endcase
      end
    end
    if (fire) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      in_tok_q    <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      in_tok_q    <= in_tok_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result word while it waits downstream
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      value_q     <= value_d;
      has_value_q <= has_value_d;
      overflow_q  <= overflow_d;
      bad_char_q  <= bad_char_d;
      eos_q       <= eos_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_o         = value_q;
  assign has_value_o     = has_value_q;
  assign overflow_o      = overflow_q;
  assign bad_char_o      = bad_char_q;
  assign end_of_string_o = eos_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({has_value_q & ~eos_q, overflow_q, bad_char_q}) &&
                    $onehot0({overflow_q, bad_char_q, eos_q}))
    else $error("result word carries conflicting flags");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !has_value_q) |-> (value_q == 32'd0))
    else $error("value not zero on a word without a token");

  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && q_op_i.kind == OP_NUL) |=> (!in_tok_q && !err_q && mag_q == 32'd0))
    else $error("state not cleared after end of string");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(fire && q_op_i.kind == OP_NUL)) |=> err_q)
    else $error("error flag dropped before end of string");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(value_q)))
    else $error("stalled result word changed");

endmodule
